// File: hw/rtl/ohlc_pkg.sv
package ohlc_pkg;

	localparam int NUM_SYMBOLS = 16;
	localparam int SLOT_W      = 4;
	localparam int TIME_W      = 64;
	localparam int MINUTE_W    = 6;
	localparam int PRICE_W     = 40;
	localparam int VOL_W       = 48;
	localparam int TAG_W       = 64;

	localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [TIME_W-1:0]   trade_time;
		logic [MINUTE_W-1:0] minute;
		logic [PRICE_W-1:0]  price;
		logic [VOL_W-1:0]    volume;
		logic [TAG_W-1:0]    tag;
	} trade_t;

	// one table entry per symbol
	typedef struct packed {
		logic [TIME_W-1:0]   last_time;
		logic [PRICE_W-1:0]  open_p;
		logic [PRICE_W-1:0]  high_p;
		logic [PRICE_W-1:0]  low_p;
		logic [PRICE_W-1:0]  close_p;
		logic [VOL_W-1:0]    volume;
		logic [MINUTE_W-1:0] minute;
		logic [TIME_W-1:0]   start_time;
	} rec_t;

	typedef struct packed {
		logic seen;
		logic active;
	} flags_t;

	typedef struct packed {
		logic drop;
		logic emit;
		rec_t next;
	} upd_t;

endpackage

// File: hw/rtl/ohlc_update.sv
module ohlc_update (
	input  ohlc_pkg::trade_t trade,
	input  ohlc_pkg::rec_t   cur,
	input  ohlc_pkg::flags_t flags,
	output ohlc_pkg::upd_t   upd
);
	import ohlc_pkg::*;

	logic            fresh;
	rec_t            base;
	logic [VOL_W:0]  vol_sum;

	always_comb begin
		upd.drop = flags.seen && (trade.trade_time < cur.last_time);
		fresh    = !flags.active || (cur.minute != trade.minute);
		upd.emit = !upd.drop && flags.active && fresh;

		base = cur;
		if (fresh) begin
			base.open_p     = trade.price;
			base.high_p     = trade.price;
			base.low_p      = trade.price;
			base.volume     = '0;
			base.minute     = trade.minute;
			base.start_time = trade.trade_time;
		end

		vol_sum = {1'b0, base.volume} + {1'b0, trade.volume};

		upd.next            = base;
		upd.next.last_time  = trade.trade_time;
		upd.next.close_p    = trade.price;
		upd.next.volume     = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
		if (base.high_p < trade.price)
			upd.next.high_p = trade.price;
		if (base.low_p > trade.price)
			upd.next.low_p = trade.price;
	end

endmodule

// File: hw/rtl/ohlc_candle_aggregator.sv
// A trade that closes a candle passes the update stage and then the output register.
// Throughput: one trade per cycle unless stalled; the symbol table is one synchronous RAM
// read at acceptance and written back by the update stage, with same-symbol forwarding.
// Output stall holds the update stage and the input together while a candle waits.
// Reset clears the per-symbol seen and open-candle flags; the table RAM is not cleared.
module ohlc_candle_aggregator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ohlc_pkg::SLOT_W-1:0]      ticker_index,
	input  logic [ohlc_pkg::TIME_W-1:0]      trade_time,
	input  logic [ohlc_pkg::MINUTE_W-1:0]    minute_of_hour,
	input  logic [ohlc_pkg::PRICE_W-1:0]     price,
	input  logic [ohlc_pkg::VOL_W-1:0]       trade_volume,
	input  logic [ohlc_pkg::TAG_W-1:0]       latency_tag,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ohlc_pkg::SLOT_W-1:0]      ticker_out,
	output logic [ohlc_pkg::PRICE_W-1:0]     open_price,
	output logic [ohlc_pkg::PRICE_W-1:0]     high_price,
	output logic [ohlc_pkg::PRICE_W-1:0]     low_price,
	output logic [ohlc_pkg::PRICE_W-1:0]     close_price,
	output logic [ohlc_pkg::VOL_W-1:0]       volume_total,
	output logic [ohlc_pkg::MINUTE_W-1:0]    candle_minute_out,
	output logic [ohlc_pkg::TIME_W-1:0]      start_time_out,
	output logic [ohlc_pkg::TAG_W-1:0]       latency_tag_out
);
	import ohlc_pkg::*;

	rec_t                   mem [NUM_SYMBOLS];
	rec_t                   rd_s1;
	rec_t                   fwd_q;
	logic                   fwd_hit_s1;
	trade_t                 trade_s1;
	logic                   valid_s1;
	logic [NUM_SYMBOLS-1:0] seen_q;
	logic [NUM_SYMBOLS-1:0] active_q;
	logic                   out_valid_q;
	rec_t                   out_rec_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [TAG_W-1:0]       out_tag_q;

	rec_t   cur;
	flags_t flags;
	upd_t   upd;
	logic   accept;
	logic   stall_s1;
	logic   adv_s1;
	logic   wr_en;

	assign stall_s1 = valid_s1 && out_valid_q && out_stall;
	assign in_stall = stall_s1;
	assign accept   = in_valid && !stall_s1;
	assign adv_s1   = valid_s1 && !stall_s1;
	assign wr_en    = adv_s1 && !upd.drop;

	// previous transaction wrote this symbol on the edge that read the RAM
	assign cur          = fwd_hit_s1 ? fwd_q : rd_s1;
	assign flags.seen   = seen_q[trade_s1.slot];
	assign flags.active = active_q[trade_s1.slot];

	ohlc_update u_update (
		.trade (trade_s1),
		.cur   (cur),
		.flags (flags),
		.upd   (upd)
	);

	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= mem[ticker_index];
		if (wr_en)
			mem[trade_s1.slot] <= upd.next;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trade_s1.slot       <= ticker_index;
			trade_s1.trade_time <= trade_time;
			trade_s1.minute     <= minute_of_hour;
			trade_s1.price      <= price;
			trade_s1.volume     <= trade_volume;
			trade_s1.tag        <= latency_tag;
		end
		if (wr_en)
			fwd_q <= upd.next;
		if (adv_s1 && upd.emit) begin
			out_rec_q  <= cur;
			out_slot_q <= trade_s1.slot;
			out_tag_q  <= trade_s1.tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_hit_s1  <= 1'b0;
			seen_q      <= '0;
			active_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1   <= 1'b1;
				fwd_hit_s1 <= wr_en && (ticker_index == trade_s1.slot);
			end else if (adv_s1) begin
				valid_s1   <= 1'b0;
				fwd_hit_s1 <= 1'b0;
			end
			if (wr_en) begin
				seen_q[trade_s1.slot]   <= 1'b1;
				active_q[trade_s1.slot] <= 1'b1;
			end
			if (adv_s1 && upd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid         = out_valid_q;
	assign ticker_out        = out_slot_q;
	assign open_price        = out_rec_q.open_p;
	assign high_price        = out_rec_q.high_p;
	assign low_price         = out_rec_q.low_p;
	assign close_price       = out_rec_q.close_p;
	assign volume_total      = out_rec_q.volume;
	assign candle_minute_out = out_rec_q.minute;
	assign start_time_out    = out_rec_q.start_time;
	assign latency_tag_out   = out_tag_q;

endmodule
